/* hw/rtl/bmd_pkg.sv */
`default_nettype none
package bmd_pkg;

  localparam int MAT_N     = 6;
  localparam int NUM_SLOTS = 15;
  localparam int CODE_W    = 3;
  localparam int IN_W      = NUM_SLOTS * CODE_W;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
  localparam int ENT_W     = 21;            // holds every minor, and the 6x6 det
  localparam int PROD_W    = 2 * ENT_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int INV_W     = 24;            // modulus for exact division
  localparam int SH_W      = 5;
  localparam int IDX_W     = 3;
  localparam int STEPS     = MAT_N - 1;
  localparam int STEP_LAT  = 7;
  localparam int LANE_DLY  = 4;             // lane stages 3..6 hold the difference
  localparam int OUT_W     = ENT_W + 2;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [CODE_W-1:0] BAD_CODE = 3'd7;
  localparam logic signed [ENT_W-1:0] DIAG_VALUE = 21'sd4;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef ent_t [MAT_N-1:0] row_t;
  typedef row_t [MAT_N-1:0] mat_t;

  typedef struct packed {
    logic vld;
    logic neg;   // odd number of row swaps
    logic dead;  // no pivot found, or bad color
    logic bad;
  } ctl_t;

  function automatic ent_t color_val(input logic [CODE_W-1:0] code);
    ent_t v;
    case (code)
      3'd0:    v = -21'sd4;
      3'd1:    v = -21'sd3;
      3'd2:    v = -21'sd2;
      3'd3:    v = -21'sd1;
      3'd4:    v = 21'sd0;
      3'd5:    v = 21'sd1;
      3'd6:    v = 21'sd2;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/gram_matrix_det6_bareiss.sv */
`default_nettype none
// Channel   | dir | payload (lowest bit first)
// in_*      | in  | tdata: edge_colors[44:0], zero fill [47:45]
// out_*     | out | tdata: det_value[20:0], det_is_zero[21], bad_color[22], zero [23]
//
// One word per cycle in steady state while the output is not stalled; the
// path is five elimination steps of seven stages each, plus the output register.
// Each step's depth is set by the Newton inverse of the previous pivot,
// which must be ready when the row lanes divide.
// rst_n is synchronous; it clears the valid and control bits only, and in_tready is low
// while it is held.
// A stalled output holds the pipeline only when the last stage is full;
// bubbles in front of it still close up and new words are taken.
module gram_matrix_det6_bareiss (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bmd_pkg::IN_BYTES_W-1:0]    in_tdata,   // edge_colors
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [bmd_pkg::OUT_BYTES_W-1:0]        out_tdata   // det_value, det_is_zero, bad_color
);

  bmd_pkg::mat_t mat0;
  bmd_pkg::ctl_t ctl0;

  bmd_pkg::mat_t mat_s [bmd_pkg::STEPS];
  bmd_pkg::ctl_t ctl_s [bmd_pkg::STEPS];
  bmd_pkg::ent_t piv_s [bmd_pkg::STEPS];

  logic          en;
  logic          out_valid_r, out_valid_nxt;
  logic [bmd_pkg::OUT_BYTES_W-1:0] out_data_r, out_data_nxt;

  bmd_pkg::ctl_t ctl_last;
  bmd_pkg::ent_t m55, det;
  logic          det_zero;

  // Build the symmetric matrix from the fifteen slots.
  always_comb begin
    int k;
    logic [bmd_pkg::CODE_W-1:0] code;
    k    = 0;
    code = '0;
    ctl0 = '0;
    for (int i = 0; i < bmd_pkg::MAT_N; i++) begin
      for (int j = 0; j < bmd_pkg::MAT_N; j++) begin
        mat0[i][j] = (i == j) ? bmd_pkg::DIAG_VALUE : '0;
      end
    end
    for (int i = 0; i < bmd_pkg::MAT_N; i++) begin
      for (int j = i + 1; j < bmd_pkg::MAT_N; j++) begin
        code = in_tdata[bmd_pkg::CODE_W*k +: bmd_pkg::CODE_W];
        if (code == bmd_pkg::BAD_CODE) ctl0.bad = 1'b1;
        mat0[i][j] = bmd_pkg::color_val(code);
        mat0[j][i] = bmd_pkg::color_val(code);
        k = k + 1;
      end
    end
    ctl0.vld  = in_tvalid;
    ctl0.dead = ctl0.bad;
  end

  for (genvar s = 0; s < bmd_pkg::STEPS; s++) begin : g_step
    if (s == 0) begin : g_first
      bmd_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .p       (bmd_pkg::IDX_W'(s)),
        .ctl_in  (ctl0),
        .mat_in  (mat0),
        .prev_in (bmd_pkg::ENT_W'(1)),
        .ctl_out (ctl_s[s]),
        .mat_out (mat_s[s]),
        .piv_out (piv_s[s])
      );
    end else begin : g_next
      bmd_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .p       (bmd_pkg::IDX_W'(s)),
        .ctl_in  (ctl_s[s-1]),
        .mat_in  (mat_s[s-1]),
        .prev_in (piv_s[s-1]),
        .ctl_out (ctl_s[s]),
        .mat_out (mat_s[s]),
        .piv_out (piv_s[s])
      );
    end
  end

  assign ctl_last = ctl_s[bmd_pkg::STEPS-1];
  assign m55      = mat_s[bmd_pkg::STEPS-1][bmd_pkg::MAT_N-1][bmd_pkg::MAT_N-1];

  // Pipeline moves unless a full last stage faces a stalled output word.
  assign en        = !(out_valid_r && !out_tready && ctl_last.vld);
  assign in_tready = en && rst_n;

  // Merge: apply swap sign and the zero cases.
  always_comb begin
    det      = ctl_last.neg ? -m55 : m55;
    det_zero = ctl_last.dead || (m55 == '0);
    if (ctl_last.dead) det = '0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_valid_r || out_tready) begin
      out_valid_nxt = ctl_last.vld;
      out_data_nxt  = {{(bmd_pkg::OUT_BYTES_W - bmd_pkg::OUT_W){1'b0}},
                       ctl_last.bad, det_zero, det};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* hw/rtl/bmd_inv.sv */
`default_nettype none
// Inverse of the odd part of the previous pivot, mod 2^INV_W, by Newton steps.
// Six register stages; sh is the pivot's trailing-zero count.
module bmd_inv (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire bmd_pkg::ent_t                prev,
  output logic      [bmd_pkg::INV_W-1:0]    inv,
  output logic      [bmd_pkg::SH_W-1:0]     sh
);

  logic [bmd_pkg::SH_W-1:0]  tz;
  logic [bmd_pkg::INV_W-1:0] dodd;
  logic signed [bmd_pkg::INV_W-1:0] pext;

  logic [bmd_pkg::INV_W-1:0] d1_r, d2_r, d3_r, d4_r;
  logic [bmd_pkg::INV_W-1:0] e1_r, e3_r, e5_r;
  logic [bmd_pkg::INV_W-1:0] x2_r, x3_r, x4_r, x5_r, x6_r;
  logic [bmd_pkg::SH_W-1:0]  t1_r, t2_r, t3_r, t4_r, t5_r, t6_r;

  always_comb begin
    tz = '0;
    for (int k = bmd_pkg::ENT_W - 1; k >= 0; k--) begin
      if (prev[k]) tz = bmd_pkg::SH_W'(k);
    end
    pext = bmd_pkg::INV_W'(prev);
    dodd = pext >>> tz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= dodd;
      t1_r <= tz;
      e1_r <= dodd * dodd;
      d2_r <= d1_r;
      t2_r <= t1_r;
      x2_r <= d1_r * (bmd_pkg::INV_W'(2) - e1_r);
      d3_r <= d2_r;
      t3_r <= t2_r;
      x3_r <= x2_r;
      e3_r <= d2_r * x2_r;
      d4_r <= d3_r;
      t4_r <= t3_r;
      x4_r <= x3_r * (bmd_pkg::INV_W'(2) - e3_r);
      t5_r <= t4_r;
      x5_r <= x4_r;
      e5_r <= d4_r * x4_r;
      t6_r <= t5_r;
      x6_r <= x5_r * (bmd_pkg::INV_W'(2) - e5_r);
    end
  end

  assign inv = x6_r;
  assign sh  = t6_r;

endmodule
`default_nettype wire

/* hw/rtl/bmd_lane.sv */
`default_nettype none
// One row of a Bareiss step: products, difference, exact divide by prev.
module bmd_lane (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [bmd_pkg::IDX_W-1:0]    p,
  input  wire logic [bmd_pkg::IDX_W-1:0]    lane_idx,
  input  wire bmd_pkg::row_t                row_in,
  input  wire bmd_pkg::row_t                prow,
  input  wire logic [bmd_pkg::INV_W-1:0]    inv,
  input  wire logic [bmd_pkg::SH_W-1:0]     sh,
  output bmd_pkg::row_t                     row_out
);

  logic signed [bmd_pkg::PROD_W-1:0] a_r [bmd_pkg::MAT_N];
  logic signed [bmd_pkg::PROD_W-1:0] b_r [bmd_pkg::MAT_N];
  bmd_pkg::row_t                      keep_r [bmd_pkg::LANE_DLY+1];
  logic [bmd_pkg::MAT_N-1:0]          upd_r  [bmd_pkg::LANE_DLY+1];
  logic signed [bmd_pkg::NUM_W-1:0]   n_r [bmd_pkg::LANE_DLY][bmd_pkg::MAT_N];

  bmd_pkg::row_t             row_nxt;
  logic [bmd_pkg::MAT_N-1:0] upd_nxt;
  logic signed [bmd_pkg::NUM_W-1:0] nsh;
  logic [bmd_pkg::INV_W-1:0] qm;

  always_comb begin
    for (int j = 0; j < bmd_pkg::MAT_N; j++) begin
      upd_nxt[j] = (lane_idx > p) && (bmd_pkg::IDX_W'(j) > p);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < bmd_pkg::MAT_N; j++) begin
        a_r[j] <= bmd_pkg::PROD_W'(row_in[j]) * bmd_pkg::PROD_W'(prow[p]);
        b_r[j] <= bmd_pkg::PROD_W'(row_in[p]) * bmd_pkg::PROD_W'(prow[j]);
        n_r[0][j] <= bmd_pkg::NUM_W'(a_r[j]) - bmd_pkg::NUM_W'(b_r[j]);
        for (int d = 1; d < bmd_pkg::LANE_DLY; d++) n_r[d][j] <= n_r[d-1][j];
      end
      keep_r[0] <= row_in;
      upd_r[0]  <= upd_nxt;
      for (int d = 1; d <= bmd_pkg::LANE_DLY; d++) begin
        keep_r[d] <= keep_r[d-1];
        upd_r[d]  <= upd_r[d-1];
      end
      row_out <= row_nxt;
    end
  end

  // n is an exact multiple of prev: shift out prev's power of two, then multiply
  // by the inverse of prev's odd part; the low bits are the quotient.
  always_comb begin
    nsh = '0;
    qm  = '0;
    row_nxt = keep_r[bmd_pkg::LANE_DLY];
    for (int j = 0; j < bmd_pkg::MAT_N; j++) begin
      nsh = n_r[bmd_pkg::LANE_DLY-1][j] >>> sh;
      qm  = nsh[bmd_pkg::INV_W-1:0] * inv;
      if (upd_r[bmd_pkg::LANE_DLY][j]) row_nxt[j] = $signed(qm[bmd_pkg::ENT_W-1:0]);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bmd_step.sv */
`default_nettype none
// One elimination step: pivot search and swap, then six row lanes.
module bmd_step (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic [bmd_pkg::IDX_W-1:0]    p,
  input  wire bmd_pkg::ctl_t                ctl_in,
  input  wire bmd_pkg::mat_t                mat_in,
  input  wire bmd_pkg::ent_t                prev_in,
  output bmd_pkg::ctl_t                     ctl_out,
  output bmd_pkg::mat_t                     mat_out,
  output bmd_pkg::ent_t                     piv_out
);

  logic                      found;
  logic [bmd_pkg::IDX_W-1:0] r;
  bmd_pkg::mat_t             mswap;
  bmd_pkg::ctl_t             ctl_nxt;

  bmd_pkg::mat_t             mat1_r;
  bmd_pkg::ctl_t             ctl_r [bmd_pkg::STEP_LAT];
  bmd_pkg::ent_t             piv_r [bmd_pkg::STEP_LAT];

  logic [bmd_pkg::INV_W-1:0] inv;
  logic [bmd_pkg::SH_W-1:0]  sh;

  always_comb begin
    found = 1'b0;
    r     = p;
    for (int k = 0; k < bmd_pkg::MAT_N; k++) begin
      if (!found && (bmd_pkg::IDX_W'(k) >= p) && (mat_in[k][p] != '0)) begin
        found = 1'b1;
        r     = bmd_pkg::IDX_W'(k);
      end
    end
    mswap    = mat_in;
    mswap[p] = mat_in[r];
    mswap[r] = mat_in[p];
    ctl_nxt      = ctl_in;
    ctl_nxt.neg  = ctl_in.neg ^ (found && (r != p));
    ctl_nxt.dead = ctl_in.dead | !found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < bmd_pkg::STEP_LAT; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_nxt;
      for (int s = 1; s < bmd_pkg::STEP_LAT; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat1_r   <= mswap;
      piv_r[0] <= mswap[p][p];
      for (int s = 1; s < bmd_pkg::STEP_LAT; s++) piv_r[s] <= piv_r[s-1];
    end
  end

  bmd_inv u_inv (
    .clk  (clk),
    .en   (en),
    .prev (prev_in),
    .inv  (inv),
    .sh   (sh)
  );

  for (genvar i = 0; i < bmd_pkg::MAT_N; i++) begin : g_lane
    bmd_lane u_lane (
      .clk      (clk),
      .en       (en),
      .p        (p),
      .lane_idx (bmd_pkg::IDX_W'(i)),
      .row_in   (mat1_r[i]),
      .prow     (mat1_r[p]),
      .inv      (inv),
      .sh       (sh),
      .row_out  (mat_out[i])
    );
  end

  assign ctl_out = ctl_r[bmd_pkg::STEP_LAT-1];
  assign piv_out = piv_r[bmd_pkg::STEP_LAT-1];

endmodule
`default_nettype wire

/* hw/rtl/bmd_checker.sv */
`default_nettype none
module bmd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [bmd_pkg::OUT_BYTES_W-1:0]   out_tdata
);

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[bmd_pkg::ENT_W] == (out_tdata[bmd_pkg::ENT_W-1:0] == '0)))
    else $error("det_is_zero disagrees with det_value");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[bmd_pkg::ENT_W+1]) |-> out_tdata[bmd_pkg::ENT_W])
    else $error("bad color word with nonzero determinant");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output word changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind gram_matrix_det6_bareiss bmd_checker u_bmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
